/* rtl/todr_pkg.sv */
// Shared types, operation codes and constants for the time-of-day register core.
// Depends on nothing; todr_off_reduce, the core and the checker import it.

package todr_pkg;

    // Operation codes carried in the operation field of an input word.
    localparam logic [2:0] OP_QUERY = 3'd0;
    localparam logic [2:0] OP_SET   = 3'd1;
    localparam logic [2:0] OP_ADD   = 3'd2;
    localparam logic [2:0] OP_SUB   = 3'd3;
    localparam logic [2:0] OP_MOVE  = 3'd4;

    // Unit codes for add and subtract.
    localparam logic [1:0] UNIT_SEC  = 2'd0;
    localparam logic [1:0] UNIT_MIN  = 2'd1;
    localparam logic [1:0] UNIT_HOUR = 2'd2;

    // Change levels reported with each result.
    localparam logic [2:0] LVL_NONE = 3'd0;
    localparam logic [2:0] LVL_SEC  = 3'd1;
    localparam logic [2:0] LVL_MIN  = 3'd2;
    localparam logic [2:0] LVL_HOUR = 3'd3;
    localparam logic [2:0] LVL_DAY  = 3'd4;

    // Comparison codes: current time against the other time.
    localparam logic [1:0] CMP_LESS    = 2'd0;
    localparam logic [1:0] CMP_EQUAL   = 2'd1;
    localparam logic [1:0] CMP_GREATER = 2'd2;

    localparam logic [4:0]  HOURS_PER_DAY    = 5'd24;
    localparam logic [5:0]  MINUTES_PER_HOUR = 6'd60;
    localparam logic [5:0]  SECONDS_PER_MIN  = 6'd60;
    localparam logic [11:0] SECONDS_PER_HOUR = 12'd3600;
    localparam logic [16:0] DAY_SECONDS      = 17'd86400;

    // Reset pattern: every field out of range, so the time reads as invalid.
    localparam logic [4:0] HOURS_RESET   = 5'd31;
    localparam logic [5:0] MINUTES_RESET = 6'd63;
    localparam logic [5:0] SECONDS_RESET = 6'd63;

    // A day is 128 * 675 seconds; the offset is reduced modulo 675 above its
    // low seven bits.
    localparam int          DAY_LOW_BITS = 7;
    localparam logic [9:0]  DAY_ODD      = 10'd675;

    // Reciprocal constants for splitting seconds of day into h:m:s.
    // Hours: floor((x >> 4) / 225), with (x >> 4) below 5400.
    localparam int          DIV225_SH  = 21;
    localparam logic [13:0] DIV225_MUL = 14'(((1 << DIV225_SH) + 224) / 225);
    // Minutes: floor((x >> 2) / 15), with (x >> 2) below 900.
    localparam int          DIV15_SH   = 14;
    localparam logic [10:0] DIV15_MUL  = 11'(((1 << DIV15_SH) + 14) / 15);

    typedef struct packed {
        logic [4:0] hh;
        logic [5:0] mm;
        logic [5:0] ss;
    } t_hms;

    // One input word as it travels down the pipeline (the offset travels
    // through the reduction unit instead).
    typedef struct packed {
        logic [2:0] operation;
        logic [1:0] unit;
        logic [5:0] amount;
        t_hms       other;
        logic       off_nz;
    } t_item;

    function automatic logic hms_ok(input t_hms t);
        return (t.hh < HOURS_PER_DAY) && (t.mm < MINUTES_PER_HOUR)
            && (t.ss < SECONDS_PER_MIN);
    endfunction

    function automatic logic [16:0] hms_total(input t_hms t);
        return 17'(t.hh) * 17'(SECONDS_PER_HOUR) + 17'(t.mm) * 17'(SECONDS_PER_MIN)
             + 17'(t.ss);
    endfunction

endpackage

/* rtl/todr_in_if.sv */
// Input channel of the time-of-day register core: valid/ready plus one word.
// Depends on nothing; the offset width is a parameter of the interface.

interface todr_in_if #(parameter int OFFSET_BITS = 25);
    logic                          valid;
    logic                          ready;
    logic [2:0]                    operation;
    logic [1:0]                    unit;
    logic [5:0]                    amount;
    logic signed [OFFSET_BITS-1:0] offset;
    logic [4:0]                    other_hours;
    logic [5:0]                    other_minutes;
    logic [5:0]                    other_seconds;

    modport source (
        output valid, operation, unit, amount, offset,
               other_hours, other_minutes, other_seconds,
        input  ready
    );
    modport sink (
        input  valid, operation, unit, amount, offset,
               other_hours, other_minutes, other_seconds,
        output ready
    );
endinterface

/* rtl/todr_out_if.sv */
// Result channel of the time-of-day register core: valid/ready plus one word.
// Depends on nothing.

interface todr_out_if;
    logic               valid;
    logic               ready;
    logic [4:0]         hours_now;
    logic [5:0]         minutes_now;
    logic [5:0]         seconds_now;
    logic               time_valid;
    logic [2:0]         change_level;
    logic               error_flag;
    logic [16:0]        total_seconds;
    logic [1:0]         compare_result;
    logic signed [17:0] seconds_to_other;

    modport source (
        output valid, hours_now, minutes_now, seconds_now, time_valid,
               change_level, error_flag, total_seconds, compare_result,
               seconds_to_other,
        input  ready
    );
    modport sink (
        input  valid, hours_now, minutes_now, seconds_now, time_valid,
               change_level, error_flag, total_seconds, compare_result,
               seconds_to_other,
        output ready
    );
endinterface

/* rtl/todr_off_reduce.sv */
// Six-stage pipeline that reduces a signed offset modulo one day and splits it into h:m:s.
// Depends on todr_pkg.

module todr_off_reduce import todr_pkg::*; #(
    parameter int OFFSET_BITS = 25
) (
    input  logic                   i_clk,
    input  logic [5:0]             i_load,
    input  logic [OFFSET_BITS-1:0] i_off_raw,
    output t_hms                   o_step
);

    localparam int HI_W   = OFFSET_BITS - DAY_LOW_BITS;
    localparam int DIV_SH = HI_W + 10;
    localparam int MUL_W  = HI_W + 1;
    localparam int PROD_W = HI_W + MUL_W;
    localparam logic [63:0] MUL64  = ((64'd1 << DIV_SH) + 64'd674) / 64'd675;
    localparam logic [MUL_W-1:0] MUL675 = MUL64[MUL_W-1:0];
    localparam logic [63:0] WRAP64 = (64'd1 << OFFSET_BITS) % 64'd86400;
    localparam logic [17:0] WRAP   = WRAP64[17:0];

    logic [PROD_W-1:0]       r_a_prod;
    logic [HI_W-1:0]         r_a_hi;
    logic [DAY_LOW_BITS-1:0] r_a_lo;
    logic                    r_a_neg;
    logic [16:0]             r_b_red;
    logic [26:0]             r_c_prod;
    logic [16:0]             r_c_red;
    logic [4:0]              r_d_hh;
    logic [11:0]             r_d_rest;
    logic [19:0]             r_e_prod;
    logic [4:0]              r_e_hh;
    logic [11:0]             r_e_rest;
    t_hms                    r_f_step;

    logic [HI_W:0]  w_b_qm;
    logic [HI_W:0]  w_b_rem;
    logic [16:0]    w_b_fold;
    logic [17:0]    w_b_sub;
    logic [16:0]    w_b_red;
    logic [4:0]     w_d_hh;
    logic [16:0]    w_d_rest;
    logic [5:0]     w_f_mm;
    logic [11:0]    w_f_ss;

    // Quotient of the upper offset bits by 675, then the remainder rebuilt
    // with the low bits gives the unsigned offset modulo one day. A set sign
    // bit takes away 2^OFFSET_BITS modulo one day.
    always_comb begin
        w_b_qm   = (HI_W+1)'(r_a_prod[PROD_W-1:DIV_SH]) * (HI_W+1)'(DAY_ODD);
        w_b_rem  = {1'b0, r_a_hi} - w_b_qm;
        w_b_fold = {w_b_rem[9:0], r_a_lo};
        w_b_sub  = {1'b0, w_b_fold} - WRAP;
        if (!r_a_neg) begin
            w_b_red = w_b_fold;
        end else if (w_b_sub[17]) begin
            w_b_red = w_b_sub[16:0] + DAY_SECONDS;
        end else begin
            w_b_red = w_b_sub[16:0];
        end
    end

    assign w_d_hh   = r_c_prod[DIV225_SH +: 5];
    assign w_d_rest = r_c_red - 17'(w_d_hh) * 17'(SECONDS_PER_HOUR);
    assign w_f_mm   = r_e_prod[DIV15_SH +: 6];
    assign w_f_ss   = r_e_rest - 12'(w_f_mm) * 12'(SECONDS_PER_MIN);

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r_a_hi   <= i_off_raw[OFFSET_BITS-1:DAY_LOW_BITS];
            r_a_lo   <= i_off_raw[DAY_LOW_BITS-1:0];
            r_a_neg  <= i_off_raw[OFFSET_BITS-1];
            r_a_prod <= PROD_W'(i_off_raw[OFFSET_BITS-1:DAY_LOW_BITS]) * PROD_W'(MUL675);
        end
        if (i_load[1]) begin
            r_b_red <= w_b_red;
        end
        if (i_load[2]) begin
            r_c_prod <= 27'(r_b_red[16:4]) * 27'(DIV225_MUL);
            r_c_red  <= r_b_red;
        end
        if (i_load[3]) begin
            r_d_hh   <= w_d_hh;
            r_d_rest <= w_d_rest[11:0];
        end
        if (i_load[4]) begin
            r_e_prod <= 20'(r_d_rest[11:2]) * 20'(DIV15_MUL);
            r_e_hh   <= r_d_hh;
            r_e_rest <= r_d_rest;
        end
        if (i_load[5]) begin
            r_f_step.hh <= r_e_hh;
            r_f_step.mm <= w_f_mm;
            r_f_step.ss <= w_f_ss[5:0];
        end
    end

    assign o_step = r_f_step;

endmodule

/* rtl/time_of_day_register_core.sv */
// Top level of the time-of-day register: pipeline control, time state and result word.
// Depends on todr_pkg, todr_in_if, todr_out_if and todr_off_reduce.
//
//  Channel | Direction | Handshake         | Word
//  --------+-----------+-------------------+----------------------------------------------
//  i_in    | in        | valid/ready, sink | operation, unit, amount, offset, other h:m:s
//  o_out   | out       | valid/ready, src  | h:m:s now, valid, level, error, total, compare
//
// One word is accepted per clock while a held result has not stalled the pipeline back to stage 0.
// The depth is set by the offset reduction: two multiply stages for the modulo-day step and
// four for the split into hours, minutes and seconds, each multiply followed by a register.
// Every stage advances whenever the stage after it is empty or moving, so a held result
// stalls only as far back as the pipeline is full. Reset is synchronous and active low; it
// empties the pipeline and loads the time with all-ones fields, which read as invalid.

module time_of_day_register_core import todr_pkg::*; #(
    parameter int OFFSET_BITS = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    todr_in_if.sink     i_in,
    todr_out_if.source  o_out
);

    // Stage 0 is the input register, stage 6 applies the word to the time
    // state, stage 7 is the output register.
    localparam int LAST = 7;
    localparam int OPS  = LAST - 1;

    logic [LAST:0]          r_vld;
    logic [LAST:0]          w_en;
    t_item                  r_item [0:OPS];
    logic [OFFSET_BITS-1:0] r_offset;
    t_item                  w_in_item;
    t_hms                   w_step;

    t_hms                   r_now;
    t_hms                   n_now;
    logic [2:0]             n_level;
    logic                   n_err;

    t_hms                   r_res_now;
    t_hms                   r_res_other;
    logic [2:0]             r_res_level;
    logic                   r_res_err;

    t_item                  w_cur;
    logic                   w_now_ok;
    logic                   w_amt_ok;
    t_hms                   w_opd;
    logic [6:0]             w_add_s;
    logic [6:0]             w_add_m;
    logic [5:0]             w_add_h;
    logic                   w_cs;
    logic                   w_cm;
    logic                   w_ch;
    t_hms                   w_sum;
    logic [6:0]             w_sub_s;
    logic [6:0]             w_sub_m;
    logic [5:0]             w_sub_h;
    t_hms                   w_dif;
    logic [2:0]             w_add_level;
    logic [2:0]             w_sub_level;
    logic [2:0]             w_move_level;

    logic                   w_res_ok;
    logic                   w_oth_ok;
    logic [16:0]            w_cur_t;
    logic [16:0]            w_oth_t;

    // ---------------------------------------------------------------------
    // Pipeline flow control. A stage may load when it is empty or when the
    // stage after it loads in the same cycle.
    // ---------------------------------------------------------------------
    always_comb begin
        w_en[LAST] = !r_vld[LAST] || o_out.ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign i_in.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int k = 1; k <= LAST; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_comb begin
        w_in_item.operation = i_in.operation;
        w_in_item.unit      = i_in.unit;
        w_in_item.amount    = i_in.amount;
        w_in_item.other.hh  = i_in.other_hours;
        w_in_item.other.mm  = i_in.other_minutes;
        w_in_item.other.ss  = i_in.other_seconds;
        w_in_item.off_nz    = |i_in.offset;
    end

    // The word fields ride along unchanged while the offset is reduced.
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_item[0] <= w_in_item;
            r_offset  <= i_in.offset;
        end
        for (int k = 1; k <= OPS; k++) begin
            if (w_en[k]) begin
                r_item[k] <= r_item[k-1];
            end
        end
    end

    // The reduced offset as h:m:s arrives aligned with r_item[OPS].
    todr_off_reduce #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_reduce (
        .i_clk     (i_clk),
        .i_load    (w_en[OPS:1]),
        .i_off_raw (r_offset),
        .o_step    (w_step)
    );

    // ---------------------------------------------------------------------
    // Time state update. Add and move share one carry chain over seconds,
    // minutes and hours; subtract has its own borrow chain. Both chains
    // assume an in-range time and operand, which the error checks ensure
    // before their results are used.
    // ---------------------------------------------------------------------
    assign w_cur    = r_item[OPS];
    assign w_now_ok = hms_ok(r_now);

    always_comb begin
        w_opd    = '0;
        w_amt_ok = 1'b0;
        case (w_cur.unit)
            UNIT_SEC: begin
                w_opd.ss = w_cur.amount;
                w_amt_ok = w_cur.amount < SECONDS_PER_MIN;
            end
            UNIT_MIN: begin
                w_opd.mm = w_cur.amount;
                w_amt_ok = w_cur.amount < MINUTES_PER_HOUR;
            end
            UNIT_HOUR: begin
                w_opd.hh = w_cur.amount[4:0];
                w_amt_ok = w_cur.amount < 6'(HOURS_PER_DAY);
            end
            default: begin
                w_opd    = '0;
                w_amt_ok = 1'b0;
            end
        endcase
        if (w_cur.operation == OP_MOVE) begin
            w_opd = w_step;
        end
    end

    always_comb begin
        w_add_s  = 7'(r_now.ss) + 7'(w_opd.ss);
        w_cs     = w_add_s >= 7'(SECONDS_PER_MIN);
        w_sum.ss = w_cs ? 6'(w_add_s - 7'(SECONDS_PER_MIN)) : w_add_s[5:0];
        w_add_m  = 7'(r_now.mm) + 7'(w_opd.mm) + 7'(w_cs);
        w_cm     = w_add_m >= 7'(MINUTES_PER_HOUR);
        w_sum.mm = w_cm ? 6'(w_add_m - 7'(MINUTES_PER_HOUR)) : w_add_m[5:0];
        w_add_h  = 6'(r_now.hh) + 6'(w_opd.hh) + 6'(w_cm);
        w_ch     = w_add_h >= 6'(HOURS_PER_DAY);
        w_sum.hh = w_ch ? 5'(w_add_h - 6'(HOURS_PER_DAY)) : w_add_h[4:0];

        w_sub_s  = 7'(r_now.ss) - 7'(w_opd.ss);
        w_dif.ss = w_sub_s[6] ? 6'(w_sub_s + 7'(SECONDS_PER_MIN)) : w_sub_s[5:0];
        w_sub_m  = 7'(r_now.mm) - 7'(w_opd.mm) - 7'(w_sub_s[6]);
        w_dif.mm = w_sub_m[6] ? 6'(w_sub_m + 7'(MINUTES_PER_HOUR)) : w_sub_m[5:0];
        w_sub_h  = 6'(r_now.hh) - 6'(w_opd.hh) - 6'(w_sub_m[6]);
        w_dif.hh = w_sub_h[5] ? 5'(w_sub_h + 6'(HOURS_PER_DAY)) : w_sub_h[4:0];
    end

    // The level names the highest unit touched: the operated unit even for
    // an amount of zero, higher when a carry or borrow reaches further.
    always_comb begin
        if (w_ch) begin
            w_add_level = LVL_DAY;
        end else if (w_cur.unit == UNIT_HOUR || w_cm) begin
            w_add_level = LVL_HOUR;
        end else if (w_cur.unit == UNIT_MIN || w_cs) begin
            w_add_level = LVL_MIN;
        end else begin
            w_add_level = LVL_SEC;
        end

        if (w_sub_h[5]) begin
            w_sub_level = LVL_DAY;
        end else if (w_cur.unit == UNIT_HOUR || w_sub_m[6]) begin
            w_sub_level = LVL_HOUR;
        end else if (w_cur.unit == UNIT_MIN || w_sub_s[6]) begin
            w_sub_level = LVL_MIN;
        end else begin
            w_sub_level = LVL_SEC;
        end

        // A move counts a whole number of days, hours or minutes in the offset as touching the
        // next lower unit (hours, minutes or seconds) even when that field comes back equal.
        if (w_sum.hh != r_now.hh || w_step == '0) begin
            w_move_level = LVL_HOUR;
        end else if (w_sum.mm != r_now.mm || (w_step.mm == '0 && w_step.ss == '0)) begin
            w_move_level = LVL_MIN;
        end else if (w_sum.ss != r_now.ss || w_step.ss == '0) begin
            w_move_level = LVL_SEC;
        end else begin
            w_move_level = LVL_NONE;
        end
    end

    always_comb begin
        n_now   = r_now;
        n_level = LVL_NONE;
        n_err   = 1'b0;
        case (w_cur.operation)
            OP_QUERY: begin
                n_now = r_now;
            end
            OP_SET: begin
                if (hms_ok(w_cur.other)) begin
                    n_now = w_cur.other;
                end else begin
                    n_err = 1'b1;
                end
            end
            OP_ADD: begin
                if (!w_now_ok || !w_amt_ok) begin
                    n_err = 1'b1;
                end else begin
                    n_now   = w_sum;
                    n_level = w_add_level;
                end
            end
            OP_SUB: begin
                if (!w_now_ok || !w_amt_ok) begin
                    n_err = 1'b1;
                end else begin
                    n_now   = w_dif;
                    n_level = w_sub_level;
                end
            end
            OP_MOVE: begin
                if (!w_now_ok) begin
                    n_err = 1'b1;
                end else if (w_cur.off_nz) begin
                    n_now   = w_sum;
                    n_level = w_move_level;
                end
            end
            default: begin
                n_err = 1'b1;
            end
        endcase
    end

    // The time state moves only when a real word passes into the output
    // register, so every word sees the state its predecessor left.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now.hh <= HOURS_RESET;
            r_now.mm <= MINUTES_RESET;
            r_now.ss <= SECONDS_RESET;
        end else if (w_en[LAST] && r_vld[OPS]) begin
            r_now <= n_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[LAST]) begin
            r_res_now   <= n_now;
            r_res_other <= w_cur.other;
            r_res_level <= n_level;
            r_res_err   <= n_err;
        end
    end

    // ---------------------------------------------------------------------
    // Result word. Totals and the comparison come from the output register
    // only, so they hold steady while the word waits.
    // ---------------------------------------------------------------------
    assign w_res_ok = hms_ok(r_res_now);
    assign w_oth_ok = hms_ok(r_res_other);
    assign w_cur_t  = w_res_ok ? hms_total(r_res_now) : '0;
    assign w_oth_t  = hms_total(r_res_other);

    assign o_out.valid         = r_vld[LAST];
    assign o_out.hours_now     = r_res_now.hh;
    assign o_out.minutes_now   = r_res_now.mm;
    assign o_out.seconds_now   = r_res_now.ss;
    assign o_out.time_valid    = w_res_ok;
    assign o_out.change_level  = r_res_level;
    assign o_out.error_flag    = r_res_err;
    assign o_out.total_seconds = w_cur_t;

    always_comb begin
        o_out.seconds_to_other = '0;
        if (w_res_ok && w_oth_ok) begin
            o_out.seconds_to_other = {1'b0, w_oth_t} - {1'b0, w_cur_t};
            if (w_cur_t < w_oth_t) begin
                o_out.compare_result = CMP_LESS;
            end else if (w_cur_t == w_oth_t) begin
                o_out.compare_result = CMP_EQUAL;
            end else begin
                o_out.compare_result = CMP_GREATER;
            end
        end else if (w_res_ok) begin
            o_out.compare_result = CMP_GREATER;
        end else if (w_oth_ok) begin
            o_out.compare_result = CMP_LESS;
        end else begin
            o_out.compare_result = CMP_EQUAL;
        end
    end

endmodule

/* rtl/todr_checker.sv */
// Port-level assertions for the time-of-day register core, bound to its top level.
// Depends on todr_pkg and time_of_day_register_core.

module todr_checker import todr_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [4:0]         i_hrs,
    input logic [5:0]         i_mins,
    input logic [5:0]         i_secs,
    input logic               i_time_valid,
    input logic [2:0]         i_change_level,
    input logic               i_error_flag,
    input logic [16:0]        i_total_seconds,
    input logic signed [17:0] i_seconds_to_other
);

    // Reset leaves no result word behind.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result word present after reset");

    // A waiting result word stays and keeps its contents.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
            && $stable({i_hrs, i_mins, i_secs, i_change_level,
                        i_error_flag, i_total_seconds, i_seconds_to_other}))
        else $error("stalled result word changed");

    // The valid mark agrees with the reported fields.
    a_valid_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_time_valid == ((i_hrs < HOURS_PER_DAY)
            && (i_mins < MINUTES_PER_HOUR) && (i_secs < SECONDS_PER_MIN)))
        else $error("time valid mark disagrees with fields");

    // An invalid time reports no total and no distance.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_time_valid |-> i_total_seconds == '0 && i_seconds_to_other == '0)
        else $error("invalid time reported a nonzero total or distance");

    // A rejected word changes nothing, so it reports no change level.
    a_reject_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_error_flag |-> i_change_level == LVL_NONE)
        else $error("rejected word reported a change level");

endmodule

bind time_of_day_register_core todr_checker u_todr_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_hrs              (o_out.hours_now),
    .i_mins             (o_out.minutes_now),
    .i_secs             (o_out.seconds_now),
    .i_time_valid       (o_out.time_valid),
    .i_change_level     (o_out.change_level),
    .i_error_flag       (o_out.error_flag),
    .i_total_seconds    (o_out.total_seconds),
    .i_seconds_to_other (o_out.seconds_to_other)
);
